>>> hdl/tbp_pkg.sv
// ----------------------------------------------------------------------------
// Tournament branch predictor package
// Shared sizes, types and counter helpers for the predictor tables.
// ----------------------------------------------------------------------------
`default_nettype none

package tbp_pkg;

	// Table size must be a power of two; the table index is the low address bits.
	localparam int TABLE_ENTRIES = 2048;
	localparam int HISTORY_BITS  = 11;
	localparam int IDX_W         = $clog2(TABLE_ENTRIES);
	localparam int CTR_W         = 2;
	localparam int ADDR_W        = 32;
	localparam int CNT_W         = 32;

	typedef logic [IDX_W-1:0]        idx_t;
	typedef logic [HISTORY_BITS-1:0] hist_t;
	typedef logic [CTR_W-1:0]        ctr_t;
	typedef logic [CNT_W-1:0]        cnt_t;
	typedef logic [ADDR_W-1:0]       addr_t;

	localparam idx_t IDX_LAST = idx_t'(TABLE_ENTRIES - 1);

	localparam ctr_t CTR_MIN            = ctr_t'(0);
	localparam ctr_t CTR_MAX            = ctr_t'(3);
	localparam ctr_t TAKEN_THRESH       = ctr_t'(2);
	localparam ctr_t COMPONENT_RESET    = CTR_MAX;
	localparam ctr_t CHOOSER_RESET      = CTR_MIN;
	localparam ctr_t CHOOSER_GSHARE_STR = CTR_MIN;
	localparam ctr_t CHOOSER_BIMOD_STR  = CTR_MAX;

	// Outcome of one branch: the prediction and the new counter values.
	typedef struct packed {
		logic pred;
		logic correct;
		ctr_t bim_next;
		ctr_t gsh_next;
		ctr_t cho_next;
	} decide_t;

	// Status of the table clearing sweep after reset.
	typedef struct packed {
		logic active;
		idx_t idx;
	} clear_t;

	function automatic ctr_t train_counter(input ctr_t c, input logic outcome);
		ctr_t r;
		r = c;
		if (outcome) begin
			if (c != CTR_MAX) r = c + ctr_t'(1);
		end else begin
			if (c != CTR_MIN) r = c - ctr_t'(1);
		end
		return r;
	endfunction

	// Address index XOR history; history bits above the index width are unused.
	function automatic idx_t gshare_index(input idx_t idx, input hist_t h);
		logic [IDX_W+HISTORY_BITS-1:0] w;
		w = {{HISTORY_BITS{1'b0}}, idx} ^ {{IDX_W{1'b0}}, h};
		return w[IDX_W-1:0];
	endfunction

endpackage

`default_nettype wire

>>> hdl/tbp_if.sv
// ----------------------------------------------------------------------------
// Tournament branch predictor channels
// Valid/ready interfaces for resolved branches and prediction results.
// ----------------------------------------------------------------------------
`default_nettype none

interface tbp_branch_if;
	logic            valid;
	logic            ready;
	tbp_pkg::addr_t  branch_address;
	logic            taken;

	modport source (output valid, output branch_address, output taken, input ready);
	modport sink   (input valid, input branch_address, input taken, output ready);
endinterface

interface tbp_result_if;
	logic            valid;
	logic            ready;
	logic            predicted_taken;
	logic            prediction_correct;
	tbp_pkg::cnt_t   correct_count;
	tbp_pkg::cnt_t   branch_count;

	modport source (output valid, output predicted_taken, output prediction_correct,
		output correct_count, output branch_count, input ready);
	modport sink   (input valid, input predicted_taken, input prediction_correct,
		input correct_count, input branch_count, output ready);
endinterface

`default_nettype wire

>>> hdl/tbp_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tbp_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 2048
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

>>> hdl/tbp_clear.sv
// ----------------------------------------------------------------------------
// Table clearing sequencer
// Sweeps every table index once after reset so the tables get their start values.
// ----------------------------------------------------------------------------
`default_nettype none

module tbp_clear (
	input  wire logic     clk,
	input  wire logic     arst_n,
	output tbp_pkg::clear_t clr
);

	logic          active_q;
	tbp_pkg::idx_t idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b1;
			idx_q    <= '0;
		end else if (active_q) begin
			idx_q <= idx_q + tbp_pkg::idx_t'(1);
			if (idx_q == tbp_pkg::IDX_LAST) begin
				active_q <= 1'b0;
			end
		end
	end

	assign clr.active = active_q;
	assign clr.idx    = idx_q;

endmodule

`default_nettype wire

>>> hdl/tbp_decide.sv
// ----------------------------------------------------------------------------
// Tournament decision
// Final prediction from the two component counters and the chooser, plus updates.
// ----------------------------------------------------------------------------
`default_nettype none

module tbp_decide (
	input  wire tbp_pkg::ctr_t bim,
	input  wire tbp_pkg::ctr_t gsh,
	input  wire tbp_pkg::ctr_t cho,
	input  wire logic          taken,
	output tbp_pkg::decide_t   dec
);

	logic          bpred;
	logic          gpred;
	logic          pred;
	tbp_pkg::ctr_t cho_next;

	assign bpred = (bim >= tbp_pkg::TAKEN_THRESH);
	assign gpred = (gsh >= tbp_pkg::TAKEN_THRESH);

	// The chooser only moves when the two predictors disagree.
	always_comb begin
		pred     = bpred;
		cho_next = cho;
		if (bpred != gpred) begin
			if (cho < tbp_pkg::TAKEN_THRESH) begin
				pred = gpred;
				if (gpred == taken) cho_next = tbp_pkg::CHOOSER_GSHARE_STR;
				else                cho_next = cho + tbp_pkg::ctr_t'(1);
			end else begin
				pred = bpred;
				if (bpred == taken) cho_next = tbp_pkg::CHOOSER_BIMOD_STR;
				else                cho_next = cho - tbp_pkg::ctr_t'(1);
			end
		end
	end

	assign dec.pred     = pred;
	assign dec.correct  = (pred == taken);
	assign dec.bim_next = tbp_pkg::train_counter(bim, taken);
	assign dec.gsh_next = tbp_pkg::train_counter(gsh, taken);
	assign dec.cho_next = cho_next;

endmodule

`default_nettype wire

>>> hdl/tournament_branch_predictor_top.sv
// Pipeline: table reads land in stage 1; the output register then holds the result.
// Throughput: one branch per cycle unless stalled; RAM reads on accept, writes on s1_adv.
// Reset: a sweep of all 2048 indexes writes table start values; branch.ready stays low
// during it. Reset clears the history, the running totals and all valid flags.
// ----------------------------------------------------------------------------
// Tournament branch predictor top level
// Bimodal and gshare counter tables with a per-address chooser, up to one branch per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tournament_branch_predictor_top (
	input  wire logic      clk,
	input  wire logic      arst_n,
	tbp_branch_if.sink     branch,
	tbp_result_if.source   result
);

	tbp_pkg::clear_t  clr;
	tbp_pkg::decide_t dec;

	tbp_pkg::hist_t hist_q;
	tbp_pkg::idx_t  rd_idx;
	tbp_pkg::idx_t  rd_gidx;
	logic           accept;
	logic           s1_adv;

	logic           valid_s1;
	logic           taken_s1;
	tbp_pkg::idx_t  idx_s1;
	tbp_pkg::idx_t  gidx_s1;

	// Write that landed in the same cycle the item in stage 1 read the tables.
	logic           fwd_s1;
	tbp_pkg::idx_t  fwd_idx_s1;
	tbp_pkg::idx_t  fwd_gidx_s1;
	tbp_pkg::ctr_t  fwd_bim_s1;
	tbp_pkg::ctr_t  fwd_gsh_s1;
	tbp_pkg::ctr_t  fwd_cho_s1;

	tbp_pkg::ctr_t  bim_rd;
	tbp_pkg::ctr_t  gsh_rd;
	tbp_pkg::ctr_t  cho_rd;
	tbp_pkg::ctr_t  bim_cur;
	tbp_pkg::ctr_t  gsh_cur;
	tbp_pkg::ctr_t  cho_cur;

	logic           we;
	tbp_pkg::idx_t  wr_idx;
	tbp_pkg::idx_t  wr_gidx;
	tbp_pkg::ctr_t  bim_wr;
	tbp_pkg::ctr_t  gsh_wr;
	tbp_pkg::ctr_t  cho_wr;

	logic           out_valid_q;
	logic           pred_q;
	logic           correct_q;
	tbp_pkg::cnt_t  correct_total_q;
	tbp_pkg::cnt_t  branch_total_q;
	tbp_pkg::cnt_t  correct_total_next;
	tbp_pkg::cnt_t  branch_total_next;

	tbp_clear u_clear (
		.clk    (clk),
		.arst_n (arst_n),
		.clr    (clr)
	);

	assign s1_adv       = valid_s1 && (!out_valid_q || result.ready);
	assign branch.ready = !clr.active && (!valid_s1 || s1_adv);
	assign accept       = branch.valid && branch.ready;

	assign rd_idx  = branch.branch_address[tbp_pkg::IDX_W-1:0];
	assign rd_gidx = tbp_pkg::gshare_index(rd_idx, hist_q);

	// The history moves on accept, so the next branch indexes with it at once.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q <= '0;
		end else if (accept) begin
			hist_q <= {hist_q[tbp_pkg::HISTORY_BITS-2:0], branch.taken};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			fwd_s1   <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
			fwd_s1   <= s1_adv;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			taken_s1    <= branch.taken;
			idx_s1      <= rd_idx;
			gidx_s1     <= rd_gidx;
			fwd_idx_s1  <= idx_s1;
			fwd_gidx_s1 <= gidx_s1;
			fwd_bim_s1  <= dec.bim_next;
			fwd_gsh_s1  <= dec.gsh_next;
			fwd_cho_s1  <= dec.cho_next;
		end
	end

	assign we      = clr.active || s1_adv;
	assign wr_idx  = clr.active ? clr.idx : idx_s1;
	assign wr_gidx = clr.active ? clr.idx : gidx_s1;
	assign bim_wr  = clr.active ? tbp_pkg::COMPONENT_RESET : dec.bim_next;
	assign gsh_wr  = clr.active ? tbp_pkg::COMPONENT_RESET : dec.gsh_next;
	assign cho_wr  = clr.active ? tbp_pkg::CHOOSER_RESET : dec.cho_next;

	tbp_ram #(.WIDTH(tbp_pkg::CTR_W), .DEPTH(tbp_pkg::TABLE_ENTRIES)) u_bim_ram (
		.clk   (clk),
		.we    (we),
		.waddr (wr_idx),
		.wdata (bim_wr),
		.re    (accept),
		.raddr (rd_idx),
		.rdata (bim_rd)
	);

	tbp_ram #(.WIDTH(tbp_pkg::CTR_W), .DEPTH(tbp_pkg::TABLE_ENTRIES)) u_gsh_ram (
		.clk   (clk),
		.we    (we),
		.waddr (wr_gidx),
		.wdata (gsh_wr),
		.re    (accept),
		.raddr (rd_gidx),
		.rdata (gsh_rd)
	);

	tbp_ram #(.WIDTH(tbp_pkg::CTR_W), .DEPTH(tbp_pkg::TABLE_ENTRIES)) u_cho_ram (
		.clk   (clk),
		.we    (we),
		.waddr (wr_idx),
		.wdata (cho_wr),
		.re    (accept),
		.raddr (rd_idx),
		.rdata (cho_rd)
	);

	assign bim_cur = (fwd_s1 && fwd_idx_s1 == idx_s1)   ? fwd_bim_s1 : bim_rd;
	assign cho_cur = (fwd_s1 && fwd_idx_s1 == idx_s1)   ? fwd_cho_s1 : cho_rd;
	assign gsh_cur = (fwd_s1 && fwd_gidx_s1 == gidx_s1) ? fwd_gsh_s1 : gsh_rd;

	tbp_decide u_decide (
		.bim   (bim_cur),
		.gsh   (gsh_cur),
		.cho   (cho_cur),
		.taken (taken_s1),
		.dec   (dec)
	);

	assign correct_total_next = correct_total_q + tbp_pkg::cnt_t'(dec.correct);
	assign branch_total_next  = branch_total_q + tbp_pkg::cnt_t'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q     <= 1'b0;
			correct_total_q <= '0;
			branch_total_q  <= '0;
		end else if (s1_adv) begin
			out_valid_q     <= 1'b1;
			correct_total_q <= correct_total_next;
			branch_total_q  <= branch_total_next;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			pred_q    <= dec.pred;
			correct_q <= dec.correct;
		end
	end

	assign result.valid              = out_valid_q;
	assign result.predicted_taken    = pred_q;
	assign result.prediction_correct = correct_q;
	assign result.correct_count      = correct_total_q;
	assign result.branch_count       = branch_total_q;

endmodule

`default_nettype wire

>>> hdl/tbp_checker.sv
// ----------------------------------------------------------------------------
// Tournament branch predictor checker
// Port-level checks on result ordering, running totals and latency.
// ----------------------------------------------------------------------------
`default_nettype none

module tbp_checker (
	input  wire logic    clk,
	input  wire logic    arst_n,
	tbp_branch_if.sink   branch,
	tbp_result_if.source result
);

	logic br_beat;
	logic res_beat;

	assign br_beat  = branch.valid && branch.ready;
	assign res_beat = result.valid && result.ready;

	// A result held back by the sink keeps valid and its running totals.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.ready |=>
			result.valid && $stable(result.branch_count) && $stable(result.correct_count))
		else $error("result payload changed while stalled");

	// Consecutive result beats count one more branch each.
	a_branch_step: assert property (@(posedge clk) disable iff (!arst_n)
		res_beat ##1 res_beat |->
			result.branch_count == $past(result.branch_count) + 32'd1)
		else $error("branch count did not step by one");

	// The correct total grows by exactly the correct flag of the newer result.
	a_correct_step: assert property (@(posedge clk) disable iff (!arst_n)
		res_beat ##1 res_beat |->
			result.correct_count ==
				$past(result.correct_count) + {31'd0, result.prediction_correct})
		else $error("correct count inconsistent with prediction flag");

	// A branch beat always leads to result.valid after the output register.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		br_beat |-> ##2 result.valid)
		else $error("no result two cycles after a branch beat");

endmodule

bind tournament_branch_predictor_top tbp_checker u_tbp_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.branch (branch),
	.result (result)
);

`default_nettype wire

>>> bench/tournament_branch_predictor_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tournament branch predictor testbench
// Streams resolved branches into the predictor, tracks every table in a
// behavioral copy and checks each prediction and running count it returns.
// ----------------------------------------------------------------------------

module tournament_branch_predictor_top_test;

	localparam int HALF_PERIOD   = 5;
	localparam int RESET_CYCLES  = 11;
	localparam int IDLE_PCT      = 23;
	localparam int RANDOM_ITEMS  = 550;
	localparam int STEADY_FIRST  = 150;
	localparam int STEADY_LAST   = 299;
	localparam int DRAIN_ITEM    = 400;
	localparam int SETTLE_CYCLES = 6;
	localparam int CYCLE_LIMIT   = 200000;
	localparam int POOL_SIZE     = 8;
	localparam int DIRECTED_ROWS = 21;

	typedef struct packed {
		logic          pred;
		logic          correct;
		tbp_pkg::cnt_t hits;
		tbp_pkg::cnt_t seen;
	} prediction_t;

	typedef struct packed {
		tbp_pkg::addr_t addr;
		logic           taken;
		logic           typed;
		logic           pred;
		logic           correct;
		tbp_pkg::cnt_t  hits;
		tbp_pkg::cnt_t  seen;
	} stim_row_t;

	// Only the opening rows after reset carry a typed-in result; the rest
	// mostly walk one entry into disagreement and chooser movement in both directions.
	stim_row_t directed_rows [DIRECTED_ROWS] = '{
		'{32'h0000_0000, 1'b1, 1'b1, 1'b1, 1'b1, 32'd1, 32'd1},
		'{32'hFFFF_FFFF, 1'b0, 1'b1, 1'b1, 1'b0, 32'd1, 32'd2},
		'{32'h8000_0800, 1'b1, 1'b1, 1'b1, 1'b1, 32'd2, 32'd3},
		'{32'h0000_0010, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0, 32'd0},
		'{32'h0000_0010, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0, 32'd0},
		'{32'h0000_0010, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0, 32'd0},
		'{32'h0000_0010, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0, 32'd0},
		'{32'h0000_0010, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0, 32'd0},
		'{32'h0000_0010, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0, 32'd0},
		'{32'h0000_0010, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0, 32'd0},
		'{32'h0000_0010, 1'b1, 1'b0, 1'b0, 1'b0, 32'd0, 32'd0},
		'{32'h0000_0010, 1'b1, 1'b0, 1'b0, 1'b0, 32'd0, 32'd0},
		'{32'h0000_0010, 1'b1, 1'b0, 1'b0, 1'b0, 32'd0, 32'd0},
		'{32'hAAAA_AAAA, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0, 32'd0},
		'{32'h5555_5555, 1'b1, 1'b0, 1'b0, 1'b0, 32'd0, 32'd0},
		'{32'hFFFF_F800, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0, 32'd0},
		'{32'h0000_07FF, 1'b1, 1'b0, 1'b0, 1'b0, 32'd0, 32'd0},
		'{32'h1234_5678, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0, 32'd0},
		'{32'hDEAD_BEEF, 1'b1, 1'b0, 1'b0, 1'b0, 32'd0, 32'd0},
		'{32'h0000_0010, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0, 32'd0},
		'{32'h0000_0010, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0, 32'd0}
	};

	logic clk = 1'b0;
	logic arst_n;
	bit   steady = 1'b0;
	int   cycle_count = 0;
	int   mismatches = 0;
	int   disagreements = 0;
	int   results_seen = 0;

	// Behavioral copy of the predictor state.
	tbp_pkg::ctr_t  bimodal_copy [tbp_pkg::TABLE_ENTRIES];
	tbp_pkg::ctr_t  gshare_copy  [tbp_pkg::TABLE_ENTRIES];
	tbp_pkg::ctr_t  chooser_copy [tbp_pkg::TABLE_ENTRIES];
	tbp_pkg::hist_t history_copy;
	tbp_pkg::cnt_t  hits_copy;
	tbp_pkg::cnt_t  seen_copy;

	prediction_t pending_predictions [$];

	tbp_branch_if branch_ch ();
	tbp_result_if result_ch ();

	tournament_branch_predictor_top u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.branch (branch_ch),
		.result (result_ch)
	);

	always #HALF_PERIOD clk = ~clk;

	function automatic tbp_pkg::ctr_t saturate_toward(input tbp_pkg::ctr_t c, input logic up);
		if (up) begin
			return (c == tbp_pkg::CTR_MAX) ? c : tbp_pkg::ctr_t'(c + 1);
		end
		return (c == tbp_pkg::CTR_MIN) ? c : tbp_pkg::ctr_t'(c - 1);
	endfunction

	// Predicts one branch from the copied tables, then trains them with its outcome.
	function automatic prediction_t resolve_branch(input tbp_pkg::addr_t addr,
		input logic taken);
		tbp_pkg::idx_t idx;
		tbp_pkg::idx_t gidx;
		logic [31:0]   folded;
		logic          bim_taken;
		logic          gsh_taken;
		logic          final_taken;
		tbp_pkg::ctr_t sel;
		prediction_t   p;
		idx = tbp_pkg::idx_t'(addr % tbp_pkg::TABLE_ENTRIES);
		folded = (32'(idx) ^ 32'(history_copy)) % tbp_pkg::TABLE_ENTRIES;
		gidx = tbp_pkg::idx_t'(folded);
		bim_taken = bimodal_copy[idx] >= tbp_pkg::TAKEN_THRESH;
		gsh_taken = gshare_copy[gidx] >= tbp_pkg::TAKEN_THRESH;
		sel = chooser_copy[idx];
		if (bim_taken == gsh_taken) begin
			final_taken = bim_taken;
		end else if (sel < tbp_pkg::TAKEN_THRESH) begin
			disagreements++;
			final_taken = gsh_taken;
			sel = (gsh_taken == taken) ? tbp_pkg::CHOOSER_GSHARE_STR
				: tbp_pkg::ctr_t'(sel + 1);
		end else begin
			disagreements++;
			final_taken = bim_taken;
			sel = (bim_taken == taken) ? tbp_pkg::CHOOSER_BIMOD_STR
				: tbp_pkg::ctr_t'(sel - 1);
		end
		chooser_copy[idx] = sel;
		bimodal_copy[idx] = saturate_toward(bimodal_copy[idx], taken);
		gshare_copy[gidx] = saturate_toward(gshare_copy[gidx], taken);
		history_copy = {history_copy[tbp_pkg::HISTORY_BITS-2:0], taken};
		if (final_taken == taken) begin
			hits_copy++;
		end
		seen_copy++;
		p.pred = final_taken;
		p.correct = (final_taken == taken);
		p.hits = hits_copy;
		p.seen = seen_copy;
		return p;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("[%0t] MISMATCH: %s", $realtime, msg);
		mismatches++;
	endtask

	// Presents one branch beat, waits for it to be taken and queues its prediction.
	task automatic send_branch(input stim_row_t row);
		prediction_t p;
		while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
			branch_ch.valid <= 1'b0;
			@(posedge clk);
		end
		branch_ch.valid <= 1'b1;
		branch_ch.branch_address <= row.addr;
		branch_ch.taken <= row.taken;
		do @(posedge clk); while (branch_ch.ready !== 1'b1);
		p = resolve_branch(row.addr, row.taken);
		if (row.typed) begin
			p = '{pred: row.pred, correct: row.correct, hits: row.hits, seen: row.seen};
		end
		pending_predictions.push_back(p);
	endtask

	always @(posedge clk) begin
		result_ch.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
	end

	always @(posedge clk) begin
		prediction_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			results_seen++;
			if (pending_predictions.size() == 0) begin
				report_mismatch($sformatf("result beat with no branch pending, branch_count %0d",
					result_ch.branch_count));
			end else begin
				want = pending_predictions.pop_front();
				if (result_ch.predicted_taken !== want.pred)
					report_mismatch($sformatf("predicted_taken %b, expected %b",
						result_ch.predicted_taken, want.pred));
				if (result_ch.prediction_correct !== want.correct)
					report_mismatch($sformatf("prediction_correct %b, expected %b",
						result_ch.prediction_correct, want.correct));
				if (result_ch.correct_count !== want.hits)
					report_mismatch($sformatf("correct_count %0d, expected %0d",
						result_ch.correct_count, want.hits));
				if (result_ch.branch_count !== want.seen)
					report_mismatch($sformatf("branch_count %0d, expected %0d",
						result_ch.branch_count, want.seen));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles with %0d results pending", cycle_count,
				pending_predictions.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin : stimulus
		tbp_pkg::idx_t pool_idx  [POOL_SIZE];
		int            pool_bias [POOL_SIZE] = '{95, 5, 50, 85, 15, 60, 100, 0};
		stim_row_t     row;
		logic [31:0]   r;
		int            k;

		arst_n <= 1'b0;
		branch_ch.valid <= 1'b0;
		branch_ch.branch_address <= '0;
		branch_ch.taken <= 1'b0;
		for (int i = 0; i < tbp_pkg::TABLE_ENTRIES; i++) begin
			bimodal_copy[i] = tbp_pkg::COMPONENT_RESET;
			gshare_copy[i] = tbp_pkg::COMPONENT_RESET;
			chooser_copy[i] = tbp_pkg::CHOOSER_RESET;
		end
		history_copy = '0;
		hits_copy = '0;
		seen_copy = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < DIRECTED_ROWS; i++) begin
			send_branch(directed_rows[i]);
		end

		// A few hot entries share nearby indexes so histories collide in gshare.
		for (int i = 0; i < POOL_SIZE; i++) begin
			pool_idx[i] = tbp_pkg::idx_t'($urandom_range(0, 63));
		end
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			steady = (n >= STEADY_FIRST) && (n <= STEADY_LAST);
			if (n == DRAIN_ITEM) begin
				branch_ch.valid <= 1'b0;
				do @(posedge clk); while (pending_predictions.size() != 0);
			end
			r = $urandom();
			row = '0;
			if ($urandom_range(0, 99) < 75) begin
				k = $urandom_range(0, POOL_SIZE - 1);
				row.addr = {r[tbp_pkg::ADDR_W-1:tbp_pkg::IDX_W], pool_idx[k]};
				row.taken = $urandom_range(0, 99) < pool_bias[k];
			end else begin
				row.addr = r;
				row.taken = 1'($urandom_range(0, 1));
			end
			send_branch(row);
		end
		steady = 1'b0;

		branch_ch.valid <= 1'b0;
		do @(posedge clk); while (pending_predictions.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Covered %0d branches (%0d directed, %0d random) and %0d result beats.",
			seen_copy, DIRECTED_ROWS, RANDOM_ITEMS, results_seen);
		$display("Components disagreed %0d times; %0d predictions missed; %0d mismatches.",
			disagreements, seen_copy - hits_copy, mismatches);
		if (mismatches == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

>>> sim.f
hdl/tbp_pkg.sv
hdl/tbp_if.sv
hdl/tbp_ram.sv
hdl/tbp_clear.sv
hdl/tbp_decide.sv
hdl/tournament_branch_predictor_top.sv
hdl/tbp_checker.sv
bench/tournament_branch_predictor_top_test.sv
